// ----- sv/tli_pkg.sv -----
// Shared types and constants for the table linear interpolator.
package tli_pkg;

  localparam int KW   = 16;
  localparam int VW   = 32;
  localparam int QW   = 32;
  localparam int CFGW = 9;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_K0, S_SCAN, S_VLO, S_VHI, S_CHK, S_DIV, S_MUL, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_ZERO  = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [VW-1:0] central;
    logic signed [VW-1:0] upper;
    logic signed [VW-1:0] lower;
  } vals_t;

endpackage

// ----- sv/tli_ifs.sv -----
// Channel interfaces for the input, result and configuration transfers.
interface tli_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic        [7:0]  entry_index;
  logic        [15:0] mass;
  logic signed [31:0] central_value;
  logic signed [31:0] upper_value;
  logic signed [31:0] lower_value;
  modport source(output valid, op, entry_index, mass, central_value, upper_value,
                 lower_value, input ready);
  modport sink(input valid, op, entry_index, mass, central_value, upper_value,
               lower_value, output ready);
endinterface

interface tli_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] central_result;
  logic signed [31:0] upper_result;
  logic signed [31:0] lower_result;
  logic        [1:0]  status;
  modport source(output valid, central_result, upper_result, lower_result, status,
                 input ready);
  modport sink(input valid, central_result, upper_result, lower_result, status,
               output ready);
endinterface

interface tli_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] entries_in_use;
  modport source(output valid, entries_in_use, input ready);
  modport sink(input valid, entries_in_use, output ready);
endinterface

// ----- sv/table_linear_interpolator_top.sv -----
// A query's run time grows with the number n of table entries: it is set by the linear
// key scan (one entry per cycle), the bit-serial divider and the multiply phases.
// A write is taken in S_IDLE; a query on a table of fewer than two entries goes to S_DONE.
// One item is in work at a time; the input is not ready until the result is registered.
// Reset clears the control state and entries_in_use; table contents stay undefined.
module table_linear_interpolator_top #(
  parameter int TABLE_DEPTH = 256
) (
  input logic      clk,
  input logic      rst_n,
  tli_in_if.sink   in_chan,
  tli_out_if.source out_chan,
  tli_cfg_if.sink  cfg_chan
);
  import tli_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = (NW > CFGW) ? NW : CFGW;
  localparam logic [MW-1:0] DEPTH_M = MW'(TABLE_DEPTH);
  localparam logic signed [50:0] VMAX = 51'sh0_7FFF_FFFF;
  localparam logic signed [50:0] VMIN = -51'sh0_8000_0000;

  state_t state_r, state_nxt;

  logic [CFGW-1:0] cfg_n_r;
  logic [NW-1:0]   n_c;
  logic [MW-1:0]   idx_m;
  logic            wr_en;
  logic            q_acc;

  logic [AW-1:0]   rd_addr;
  logic [KW-1:0]   rkey;
  vals_t           rvals;
  vals_t           wvals;

  logic [KW-1:0]   m_r;
  logic [AW-1:0]   i_r;
  logic [KW-1:0]   kprev_r;
  logic            base_hi_r;
  logic signed [KW:0] dd1_r, dd2_r;
  vals_t           vlo_r, vhi_r;
  logic [QW-1:0]   f_r;
  logic            fneg_r;
  logic [1:0]      vsel_r;
  logic [2:0]      ph_r;
  logic [32:0]     dmag_r;
  logic            dneg_r;
  logic [48:0]     mul_r;
  logic [64:0]     acc_r;
  logic signed [31:0] res_r [3];
  logic            sat_r;
  status_t         stat_r;

  logic            out_valid_r;
  logic signed [31:0] out_c_r, out_u_r, out_l_r;
  status_t         out_s_r;

  logic            hit, last, scan_end;
  logic [KW-1:0]   kbase;
  logic [KW:0]     a1, a2;
  logic            div_start, div_busy;
  logic [QW-1:0]   div_q;
  logic signed [31:0] vlo_s, vhi_s, vb;
  logic signed [32:0] diff;
  logic [16:0]     mul_a;
  logic [48:0]     mul_p;
  logic signed [50:0] delta, rsum;
  logic            out_free;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign n_c   = (MW'(cfg_n_r) > DEPTH_M) ? NW'(TABLE_DEPTH) : NW'(cfg_n_r);
  assign idx_m = MW'(in_chan.entry_index);
  assign wr_en = in_chan.valid && in_chan.ready && (in_chan.op == OP_WRITE) &&
                 (idx_m < DEPTH_M);
  assign q_acc = in_chan.valid && in_chan.ready && (in_chan.op == OP_QUERY);
  assign wvals = '{central: in_chan.central_value, upper: in_chan.upper_value,
                   lower: in_chan.lower_value};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_n_r <= '0;
    end else if (cfg_chan.valid) begin
      cfg_n_r <= cfg_chan.entries_in_use;
    end
  end

  tli_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_m[AW-1:0]),
    .wkey  (in_chan.mass),
    .wvals (wvals),
    .raddr (rd_addr),
    .rkey  (rkey),
    .rvals (rvals)
  );

  assign hit = ((m_r >= kprev_r) && (m_r < rkey)) || ((m_r < kprev_r) && (i_r == '0));
  assign last = (NW'(i_r) == n_c - NW'(2));
  assign scan_end = hit || last;
  assign kbase = hit ? kprev_r : rkey;
  assign a1 = dd1_r[KW] ? -dd1_r : dd1_r;
  assign a2 = dd2_r[KW] ? -dd2_r : dd2_r;
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    rd_addr   = '0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_acc) begin
          state_nxt = (n_c < NW'(2)) ? S_DONE : S_K0;
        end
      end
      S_K0: begin
        rd_addr   = AW'(1);
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_end) begin
          rd_addr   = i_r;
          state_nxt = S_VLO;
        end else begin
          rd_addr = i_r + AW'(2);
        end
      end
      S_VLO: begin
        rd_addr   = i_r + AW'(1);
        state_nxt = S_VHI;
      end
      S_VHI: state_nxt = S_CHK;
      S_CHK: begin
        if (dd2_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (ph_r == 3'd4 && vsel_r == 2'd2) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  tli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({a1[KW-1:0], {KW{1'b0}}}),
    .divisor  (a2[KW-1:0]),
    .busy     (div_busy),
    .quot     (div_q)
  );

  always_comb begin
    case (vsel_r)
      2'd0:    begin vlo_s = vlo_r.central; vhi_s = vhi_r.central; end
      2'd1:    begin vlo_s = vlo_r.upper;   vhi_s = vhi_r.upper;   end
      default: begin vlo_s = vlo_r.lower;   vhi_s = vhi_r.lower;   end
    endcase
    vb    = base_hi_r ? vhi_s : vlo_s;
    diff  = {vhi_s[31], vhi_s} - {vlo_s[31], vlo_s};
    mul_a = (ph_r == 3'd1) ? {1'b0, dmag_r[15:0]} : dmag_r[32:16];
    mul_p = {32'b0, mul_a} * {17'b0, f_r};
    delta = (dneg_r ^ fneg_r) ? -$signed({2'b00, acc_r[64:16]})
                              : $signed({2'b00, acc_r[64:16]});
    rsum  = 51'(vb) + delta;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        m_r     <= in_chan.mass;
        i_r     <= '0;
        sat_r   <= 1'b0;
        res_r[0] <= '0;
        res_r[1] <= '0;
        res_r[2] <= '0;
        stat_r  <= ST_SHORT;
      end
      S_K0: kprev_r <= rkey;
      S_SCAN: begin
        if (scan_end) begin
          base_hi_r <= !hit;
          dd1_r     <= $signed({1'b0, m_r}) - $signed({1'b0, kbase});
          dd2_r     <= $signed({1'b0, rkey}) - $signed({1'b0, kprev_r});
        end else begin
          kprev_r <= rkey;
          i_r     <= i_r + 1'b1;
        end
      end
      S_VLO: vlo_r <= rvals;
      S_VHI: vhi_r <= rvals;
      S_CHK: begin
        fneg_r <= dd1_r[KW] ^ dd2_r[KW];
        stat_r <= ST_ZERO;
      end
      S_DIV: begin
        f_r    <= div_q;
        vsel_r <= '0;
        ph_r   <= '0;
      end
      S_MUL: begin
        case (ph_r)
          3'd0: begin
            dneg_r <= diff[32];
            dmag_r <= diff[32] ? 33'(-diff) : 33'(diff);
            ph_r   <= 3'd1;
          end
          3'd1: begin
            mul_r <= mul_p;
            ph_r  <= 3'd2;
          end
          3'd2: begin
            acc_r <= 65'(mul_r);
            mul_r <= mul_p;
            ph_r  <= 3'd3;
          end
          3'd3: begin
            acc_r <= acc_r + {mul_r, 16'b0};
            ph_r  <= 3'd4;
          end
          default: begin
            if (rsum > VMAX) begin
              res_r[vsel_r] <= 32'sh7FFF_FFFF;
              sat_r <= 1'b1;
            end else if (rsum < VMIN) begin
              res_r[vsel_r] <= 32'sh8000_0000;
              sat_r <= 1'b1;
            end else begin
              res_r[vsel_r] <= rsum[31:0];
            end
            ph_r   <= 3'd0;
            vsel_r <= vsel_r + 1'b1;
            if (vsel_r == 2'd2) begin
              stat_r <= (sat_r || rsum > VMAX || rsum < VMIN) ? ST_SAT : ST_OK;
            end
          end
        endcase
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_c_r <= res_r[0];
      out_u_r <= res_r[1];
      out_l_r <= res_r[2];
      out_s_r <= stat_r;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.central_result = out_c_r;
  assign out_chan.upper_result   = out_u_r;
  assign out_chan.lower_result   = out_l_r;
  assign out_chan.status         = out_s_r;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.status == ST_SHORT || out_chan.status == ST_ZERO)
    |-> out_chan.central_result == 0 && out_chan.upper_result == 0 &&
        out_chan.lower_result == 0)
    else $error("error status with nonzero result");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> NW'(i_r) <= n_c - NW'(2))
    else $error("scan index beyond table");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == S_DIV)
    else $error("divider busy outside divide state");
`endif

endmodule

// ----- sv/tli_table.sv -----
// Key and value memories with one write port and one registered read port.
module tli_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [tli_pkg::KW-1:0] wkey,
  input  tli_pkg::vals_t         wvals,
  input  logic [AW-1:0]          raddr,
  output logic [tli_pkg::KW-1:0] rkey,
  output tli_pkg::vals_t         rvals
);
  import tli_pkg::*;

  logic [KW-1:0] key_mem [DEPTH];
  vals_t         val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wvals;
    end
    rkey  <= key_mem[raddr];
    rvals <= val_mem[raddr];
  end

endmodule

// ----- sv/tli_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module tli_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [tli_pkg::QW-1:0] dividend,
  input  logic [tli_pkg::KW-1:0] divisor,
  output logic                   busy,
  output logic [tli_pkg::QW-1:0] quot
);
  import tli_pkg::*;

  localparam int CW = $clog2(QW);

  logic [KW-1:0]        rem_r;
  logic [QW-1:0]        dvd_r;
  logic [KW-1:0]        div_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic [KW:0]          rem_s;
  logic                 ge;
  logic [KW:0]          rem_nxt;

  always_comb begin
    rem_s   = {rem_r, dvd_r[QW-1]};
    ge      = rem_s >= {1'b0, div_r};
    rem_nxt = ge ? rem_s - {1'b0, div_r} : rem_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      rem_r  <= '0;
      dvd_r  <= dividend;
      div_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt[KW-1:0];
      dvd_r <= {dvd_r[QW-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(QW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = dvd_r;

endmodule
